[src/double_hash_process_page_table_unit_assert.svh]
// Assertion macros for the process page table unit and its checker.
// No dependencies; take in with `include by bare file name.
`ifndef DOUBLE_HASH_PROCESS_PAGE_TABLE_UNIT_ASSERT_SVH
`define DOUBLE_HASH_PROCESS_PAGE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define DHPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dhpt: same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define DHPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dhpt: next-cycle check failed");

`endif

[src/dhpt_pkg.sv]
// Shared constants, codes and controller/datapath interface types
// for the process page table unit. No dependencies.
package dhpt_pkg;

   // Table geometry; both must be powers of two.
   localparam int SLOTS      = 16;
   localparam int PAGE_WORDS = 16;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int ADDR_W = (SLOTS * PAGE_WORDS > 1) ? $clog2(SLOTS * PAGE_WORDS) : 1;

   localparam int FUNC_W   = 3;
   localparam int PID_W    = 32;
   localparam int OFF_W    = 8;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_OUT_W = 8;

   localparam logic [FUNC_W-1:0] F_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] F_SEARCH = 3'd1;
   localparam logic [FUNC_W-1:0] F_WRITE  = 3'd2;
   localparam logic [FUNC_W-1:0] F_READ   = 3'd3;
   localparam logic [FUNC_W-1:0] F_DELETE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic load;     // capture request, start probe walk
      logic step;     // examine one probe slot
      logic commit;   // apply table update, access page store
      logic respond;  // present result for one cycle
   } dp_cmd_type;

   typedef struct packed {
      logic probe_last;
   } dp_status_type;

endpackage

[src/dhpt_ctrl.sv]
// Sequencer for the process page table unit: walks load, probe,
// commit and page-access phases. Depends on dhpt_pkg.
module dhpt_ctrl import dhpt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_PROBE  = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;
   localparam logic [1:0] S_MEM    = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            cmd.step = 1'b1;
            if (status.probe_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_MEM;
         end
         S_MEM: begin
            // read data is registered now
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/dhpt_dp.sv]
// Datapath of the process page table unit: slot table, free-page stack,
// probe walker, decision logic and page store. Depends on dhpt_pkg.
module dhpt_dp import dhpt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic [FUNC_W-1:0]      req_func,
   input  logic [PID_W-1:0]       req_pid,
   input  logic [OFF_W-1:0]       req_word_offset,
   input  logic signed [WORD_W-1:0] req_wdata,
   output logic                   rsp_strobe,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [SLOT_OUT_W-1:0]  rsp_slot,
   output logic signed [WORD_W-1:0] rsp_rdata
);

   // captured request
   logic [FUNC_W-1:0] func_ff;
   logic [PID_W-1:0]  pid_ff;
   logic [OFF_W-1:0]  off_ff;
   word_type          wdata_ff;

   // probe walker
   logic [SLOT_W-1:0] pos_ff, pos_in;
   logic [SLOT_W-1:0] step_ff, step_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] found_slot_ff, found_slot_in;
   logic              empty_ff, empty_in;
   logic [SLOT_W-1:0] empty_slot_ff, empty_slot_in;

   // slot table and free stack
   logic [PID_W-1:0]  key_ff  [SLOTS];
   logic [PID_W-1:0]  key_in  [SLOTS];
   logic              kval_ff [SLOTS];
   logic              kval_in [SLOTS];
   logic [SLOT_W-1:0] page_ff [SLOTS];
   logic [SLOT_W-1:0] page_in [SLOTS];
   logic [SLOT_W-1:0] free_ff [SLOTS];
   logic [SLOT_W-1:0] free_in [SLOTS];
   logic [CNT_W-1:0]  free_top_ff, free_top_in;
   logic [CNT_W-1:0]  used_ff, used_in;

   // page store
   word_type          mem [SLOTS * PAGE_WORDS];
   word_type          mem_q_ff;
   logic [ADDR_W-1:0] addr;
   logic              mem_wr;

   // result
   logic                  strobe_ff, strobe_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic                  read_ok_ff, read_ok_in;

   logic              hit;
   logic              off_bad;
   logic [CNT_W-1:0]  pop_top;

   assign status.probe_last = (cnt_ff == SLOT_W'(SLOTS - 1));
   assign hit     = kval_ff[pos_ff] && (key_ff[pos_ff] == pid_ff) && (pid_ff != '0);
   assign off_bad = ({1'b0, off_ff} >= (OFF_W + 1)'(PAGE_WORDS));
   assign pop_top = free_top_ff - CNT_W'(1);
   assign addr    = ADDR_W'(page_ff[found_slot_ff]) * ADDR_W'(PAGE_WORDS)
                    + ADDR_W'(off_ff);

   // probe walk
   always_comb begin
      pos_in        = pos_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      empty_in      = empty_ff;
      empty_slot_in = empty_slot_ff;
      if (cmd.load) begin
         pos_in   = req_pid[SLOT_W-1:0];
         step_in  = req_pid[2*SLOT_W-1:SLOT_W] | SLOT_W'(1);
         cnt_in   = '0;
         found_in = 1'b0;
         empty_in = 1'b0;
      end else if (cmd.step) begin
         if (hit && !found_ff) begin
            found_in      = 1'b1;
            found_slot_in = pos_ff;
         end
         // remember the first free slot on the sequence
         if (!kval_ff[pos_ff] && !empty_ff) begin
            empty_in      = 1'b1;
            empty_slot_in = pos_ff;
         end
         pos_in = pos_ff + step_ff;
         cnt_in = cnt_ff + SLOT_W'(1);
      end
   end

   // decide and update at commit
   always_comb begin
      key_in      = key_ff;
      kval_in     = kval_ff;
      page_in     = page_ff;
      free_in     = free_ff;
      free_top_in = free_top_ff;
      used_in     = used_ff;
      status_in   = status_ff;
      slot_in     = slot_ff;
      read_ok_in  = read_ok_ff;
      mem_wr      = 1'b0;
      strobe_in   = cmd.respond;
      if (cmd.commit) begin
         status_in  = ST_NOT_FOUND;
         slot_in    = '0;
         read_ok_in = 1'b0;
         case (func_ff)
            F_INSERT: begin
               if (used_ff >= CNT_W'(SLOTS)) begin
                  status_in = ST_FULL;
               end else if (pid_ff == '0) begin
                  status_in = ST_NOT_FOUND;
               end else if (found_ff) begin
                  status_in = ST_DUPLICATE;
               end else if (empty_ff && (free_top_ff != '0)) begin
                  status_in              = ST_OK;
                  slot_in                = empty_slot_ff;
                  key_in[empty_slot_ff]  = pid_ff;
                  kval_in[empty_slot_ff] = 1'b1;
                  page_in[empty_slot_ff] = free_ff[pop_top[SLOT_W-1:0]];
                  free_top_in            = pop_top;
                  used_in                = used_ff + CNT_W'(1);
               end else begin
                  status_in = ST_FULL;
               end
            end
            F_SEARCH: begin
               if (found_ff) begin
                  status_in = ST_OK;
                  slot_in   = found_slot_ff;
               end
            end
            F_WRITE, F_READ: begin
               if (off_bad) begin
                  status_in = ST_RANGE;
               end else if (found_ff) begin
                  status_in  = ST_OK;
                  slot_in    = found_slot_ff;
                  mem_wr     = (func_ff == F_WRITE);
                  read_ok_in = (func_ff == F_READ);
               end
            end
            F_DELETE: begin
               if (found_ff) begin
                  status_in = ST_OK;
                  slot_in   = found_slot_ff;
                  // return the page to the stack
                  if (free_top_ff < CNT_W'(SLOTS)) begin
                     free_in[free_top_ff[SLOT_W-1:0]] = page_ff[found_slot_ff];
                     free_top_in = free_top_ff + CNT_W'(1);
                  end
                  kval_in[found_slot_ff] = 1'b0;
                  page_in[found_slot_ff] = '0;
                  if (used_ff != '0) begin
                     used_in = used_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
               status_in = ST_NOT_FOUND;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kval_ff     <= '{default: 1'b0};
         free_top_ff <= CNT_W'(SLOTS);
         used_ff     <= '0;
         strobe_ff   <= 1'b0;
         for (int j = 0; j < SLOTS; j++) begin
            free_ff[j] <= SLOT_W'(j);
         end
      end else begin
         kval_ff     <= kval_in;
         free_top_ff <= free_top_in;
         used_ff     <= used_in;
         strobe_ff   <= strobe_in;
         free_ff     <= free_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         pid_ff   <= req_pid;
         off_ff   <= req_word_offset;
         wdata_ff <= word_type'(req_wdata);
      end
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      cnt_ff        <= cnt_in;
      found_ff      <= found_in;
      found_slot_ff <= found_slot_in;
      empty_ff      <= empty_in;
      empty_slot_ff <= empty_slot_in;
      key_ff        <= key_in;
      page_ff       <= page_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      read_ok_ff    <= read_ok_in;
   end

   // page store, registered read
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (mem_wr) begin
            mem[addr] <= wdata_ff;
         end
         mem_q_ff <= mem[addr];
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_slot   = SLOT_OUT_W'(slot_ff);

   // hold the read word until the result transfer
   word_type rdata_ff;
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rdata_ff <= read_ok_ff ? mem_q_ff : '0;
      end
   end
   assign rsp_rdata = $signed(rdata_ff);

endmodule

[src/double_hash_process_page_table_unit.sv]
// Top level of the process page table unit: a hashed table of process
// entries, each owning one page of data words. Depends on dhpt_pkg, dhpt_ctrl, dhpt_dp.
//
// Request channel: drive req_func, req_pid, req_word_offset and req_wdata with
// start high; the request transfers at a rising edge where busy is low.
// Result channel: rsp_status, rsp_slot and rsp_rdata are valid for exactly
// one cycle while rsp_strobe is high, and transfer at the edge ending it.
// The receiver has no way to stall results and must take them when shown.
// busy stays high while an operation is in progress and is low while its result
// is shown; a new request can transfer at the same edge as the previous result.
// Each operation walks the probe phase, which reads one slot-table entry per
// cycle over all SLOTS probes, then a commit state that applies the table
// update and accesses the page store, then a state that presents the result.
// Reset (synchronous, active high) empties the slot table, refills the free
// page stack with pages 0 to SLOTS-1 and idles the sequencer; no sweep
// follows. Page words are undefined until written.
module double_hash_process_page_table_unit import dhpt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [PID_W-1:0]         req_pid,
   input  logic [OFF_W-1:0]         req_word_offset,
   input  logic signed [WORD_W-1:0] req_wdata,
   output logic                     rsp_strobe,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_OUT_W-1:0]    rsp_slot,
   output logic signed [WORD_W-1:0] rsp_rdata
);

   dp_cmd_type    cmd;
   dp_status_type dp_status;

   dhpt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (dp_status),
      .cmd    (cmd),
      .busy   (busy)
   );

   dhpt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (dp_status),
      .req_func        (req_func),
      .req_pid         (req_pid),
      .req_word_offset (req_word_offset),
      .req_wdata       (req_wdata),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_rdata       (rsp_rdata)
   );

endmodule

[src/dhpt_checker.sv]
// Port-level checker for the process page table unit, bound to the top level.
// Depends on dhpt_pkg and double_hash_process_page_table_unit_assert.svh.
`include "double_hash_process_page_table_unit_assert.svh"

module dhpt_checker import dhpt_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_strobe,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic [SLOT_OUT_W-1:0]    rsp_slot,
   input logic signed [WORD_W-1:0] rsp_rdata
);

   // an accepted request keeps the unit busy next cycle
   `DHPT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // one strobe per result
   `DHPT_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)

   // a result only appears once the unit is free again
   `DHPT_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy)

   // failed operations report no slot and no data
   `DHPT_ASSERT_NOW(a_fail_clean, clock, reset, rsp_strobe && (rsp_status != ST_OK),
      (rsp_slot == '0) && (rsp_rdata == '0))

endmodule

bind double_hash_process_page_table_unit dhpt_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_status (rsp_status),
   .rsp_slot   (rsp_slot),
   .rsp_rdata  (rsp_rdata)
);

[verif/tb_double_hash_process_page_table_unit.sv]
// Self-checking testbench for double_hash_process_page_table_unit: directed rows, then
// random insert/search/write/read/delete traffic checked against a behavioral table.
// Depends on dhpt_pkg and the unit's RTL.
module tb_double_hash_process_page_table_unit import dhpt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 1850;
   localparam int NUM_DIRECTED  = 25;
   localparam int POOL_SIZE     = 32;
   localparam int NO_SLOT       = -1;
   localparam int WORDS_TOTAL   = SLOTS * PAGE_WORDS;
   localparam int MAX_PRINTED   = 40;

   // func codes the unit does not decode
   localparam logic [FUNC_W-1:0] F_RESERVED_LO = 3'd5;
   localparam logic [FUNC_W-1:0] F_RESERVED_HI = 3'd7;

   localparam logic GIVEN     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [PID_W-1:0]         pid;
      logic [OFF_W-1:0]         off;
      logic signed [WORD_W-1:0] wdata;
   } page_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot;
      logic [WORD_W-1:0]     rdata;
   } page_rsp_type;

   typedef struct packed {
      page_req_type req;
      logic         given;
      page_rsp_type rsp;
   } dir_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [FUNC_W-1:0]        req_func = '0;
   logic [PID_W-1:0]         req_pid = '0;
   logic [OFF_W-1:0]         req_word_offset = '0;
   logic signed [WORD_W-1:0] req_wdata = '0;
   logic                     rsp_strobe;
   logic [STATUS_W-1:0]      rsp_status;
   logic [SLOT_OUT_W-1:0]    rsp_slot;
   logic signed [WORD_W-1:0] rsp_rdata;

   // behavioral copy of the table
   logic [PID_W-1:0]  tbl_key    [SLOTS];
   logic [SLOT_W-1:0] tbl_page   [SLOTS];
   logic [SLOT_W-1:0] free_stack [SLOTS];
   logic [CNT_W-1:0]  free_top;
   logic [CNT_W-1:0]  used_count;
   logic [WORD_W-1:0] page_words   [WORDS_TOTAL];
   bit                word_written [WORDS_TOTAL];

   page_rsp_type     pending_results[$];
   logic [PID_W-1:0] pid_pool [POOL_SIZE];
   dir_row_type      directed_rows [NUM_DIRECTED];
   int               mismatch_count = 0;
   int               cycle_count = 0;

   double_hash_process_page_table_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_pid(req_pid), .req_word_offset(req_word_offset),
      .req_wdata(req_wdata), .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_slot(rsp_slot), .rsp_rdata(rsp_rdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("double_hash_process_page_table_unit regression: fail");
         $finish;
      end
   end

   function automatic int probe_slot(logic [PID_W-1:0] k, int i);
      int unsigned base, step;
      base = k % SLOTS;
      step = (k / SLOTS) % SLOTS;
      if (step % 2 == 0)
         step = step + 1;
      return int'((base + i * step) % SLOTS);
   endfunction

   function automatic int find_slot(logic [PID_W-1:0] k);
      int hit;
      int s;
      hit = NO_SLOT;
      if (k != '0) begin
         for (int i = 0; i < SLOTS; i++) begin
            s = probe_slot(k, i);
            if (hit == NO_SLOT && tbl_key[s] == k)
               hit = s;
         end
      end
      return hit;
   endfunction

   function automatic int word_index(int s, logic [OFF_W-1:0] off);
      return int'(tbl_page[s]) * PAGE_WORDS + int'(off);
   endfunction

   function automatic page_rsp_type predict_page_table(page_req_type rq);
      page_rsp_type rsp;
      int           s;
      bit           placed;
      rsp = '{ST_NOT_FOUND, '0, '0};
      case (rq.func)
         F_INSERT: begin
            if (used_count >= SLOTS) begin
               rsp.status = ST_FULL;
            end else if (rq.pid == '0) begin
               rsp.status = ST_NOT_FOUND;
            end else if (find_slot(rq.pid) != NO_SLOT) begin
               rsp.status = ST_DUPLICATE;
            end else begin
               rsp.status = ST_FULL;
               placed = 1'b0;
               if (free_top > 0) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     s = probe_slot(rq.pid, i);
                     if (!placed && tbl_key[s] == '0) begin
                        placed = 1'b1;
                        free_top = free_top - 1'b1;
                        tbl_key[s] = rq.pid;
                        tbl_page[s] = free_stack[free_top];
                        used_count = used_count + 1'b1;
                        rsp.status = ST_OK;
                        rsp.slot = SLOT_OUT_W'(s);
                     end
                  end
               end
            end
         end
         F_SEARCH: begin
            s = find_slot(rq.pid);
            if (s != NO_SLOT) begin
               rsp.status = ST_OK;
               rsp.slot = SLOT_OUT_W'(s);
            end
         end
         F_WRITE, F_READ: begin
            if (rq.off >= PAGE_WORDS) begin
               rsp.status = ST_RANGE;
            end else begin
               s = find_slot(rq.pid);
               if (s != NO_SLOT) begin
                  rsp.status = ST_OK;
                  rsp.slot = SLOT_OUT_W'(s);
                  if (rq.func == F_WRITE) begin
                     page_words[word_index(s, rq.off)] = rq.wdata;
                     word_written[word_index(s, rq.off)] = 1'b1;
                  end else begin
                     rsp.rdata = page_words[word_index(s, rq.off)];
                  end
               end
            end
         end
         F_DELETE: begin
            s = find_slot(rq.pid);
            if (s != NO_SLOT) begin
               rsp.status = ST_OK;
               rsp.slot = SLOT_OUT_W'(s);
               if (free_top < SLOTS) begin
                  free_stack[free_top] = tbl_page[s];
                  free_top = free_top + 1'b1;
               end
               tbl_key[s] = '0;
               tbl_page[s] = '0;
               if (used_count > 0)
                  used_count = used_count - 1'b1;
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic logic [PID_W-1:0] live_pid();
      int               first;
      logic [PID_W-1:0] k;
      first = $urandom_range(0, SLOTS - 1);
      k = '0;
      for (int j = SLOTS - 1; j >= 0; j--) begin
         if (tbl_key[(first + j) % SLOTS] != '0)
            k = tbl_key[(first + j) % SLOTS];
      end
      return k;
   endfunction

   function automatic page_req_type random_request(int insert_weight);
      page_req_type     rq;
      logic [PID_W-1:0] k;
      int               r;
      int               s;
      int               off;
      bit               found;
      rq.pid = pid_pool[$urandom_range(0, POOL_SIZE - 1)];
      rq.off = OFF_W'($urandom_range(0, PAGE_WORDS - 1));
      rq.wdata = $urandom;
      if ($urandom_range(0, 99) < insert_weight) begin
         rq.func = F_INSERT;
         if ($urandom_range(0, 3) == 0)
            rq.pid = $urandom;
      end else begin
         k = live_pid();
         if (k != '0 && $urandom_range(0, 9) != 0)
            rq.pid = k;
         r = $urandom_range(0, 99);
         if (r < 15)
            rq.func = F_SEARCH;
         else if (r < 45)
            rq.func = F_WRITE;
         else if (r < 75)
            rq.func = F_READ;
         else if (r < 88)
            rq.func = F_DELETE;
         else begin
            rq.func = FUNC_W'($urandom_range(F_INSERT, F_DELETE));
            case ($urandom_range(0, 3))
               0: rq.func = FUNC_W'($urandom_range(F_RESERVED_LO, F_RESERVED_HI));
               1: rq.pid = '0;
               2: begin
                  rq.func = FUNC_W'($urandom_range(F_WRITE, F_READ));
                  rq.off = OFF_W'($urandom_range(PAGE_WORDS, 255));
               end
               default: rq.pid = $urandom;
            endcase
         end
      end
      // steer reads onto words that were written; turn the read into a write if none are
      s = find_slot(rq.pid);
      if (rq.func == F_READ && rq.off < PAGE_WORDS && s != NO_SLOT) begin
         found = 1'b0;
         for (int j = PAGE_WORDS - 1; j >= 0; j--) begin
            off = (int'(rq.off) + j) % PAGE_WORDS;
            if (word_written[int'(tbl_page[s]) * PAGE_WORDS + off]) begin
               found = 1'b1;
               rq.off = OFF_W'(off);
            end
         end
         if (!found)
            rq.func = F_WRITE;
      end
      return rq;
   endfunction

   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 4);
      else if (r < 98)
         return $urandom_range(5, 20);
      return $urandom_range(21, 60);
   endfunction

   task automatic report_mismatch(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch at cycle %0d: %s expected %0h got %0h", cycle_count, what, want, got);
   endtask

   task automatic send_request(page_req_type rq, logic given, page_rsp_type given_rsp,
                               int gap);
      page_rsp_type pred;
      req_func <= rq.func;
      req_pid <= rq.pid;
      req_word_offset <= rq.off;
      req_wdata <= rq.wdata;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pred = predict_page_table(rq);
      pending_results.insert(pending_results.size(), given ? given_rsp : pred);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin : result_check
      page_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, status", '0, WORD_W'(rsp_status));
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", WORD_W'(want.status), WORD_W'(rsp_status));
            if (rsp_slot !== want.slot)
               report_mismatch("slot", WORD_W'(want.slot), WORD_W'(rsp_slot));
            if (rsp_rdata !== want.rdata)
               report_mismatch("rdata", want.rdata, rsp_rdata);
         end
      end
   end

   initial begin : stimulus
      page_req_type     rq;
      page_rsp_type     full_rsp;
      logic [PID_W-1:0] k;
      int               random_sent;
      int               phase;
      int               phase_len;
      int               insert_weight;
      bit               quiet;

      for (int j = 0; j < SLOTS; j++) begin
         tbl_key[j] = '0;
         tbl_page[j] = '0;
         free_stack[j] = SLOT_W'(j);
      end
      free_top = CNT_W'(SLOTS);
      used_count = '0;
      for (int j = 0; j < WORDS_TOTAL; j++) begin
         page_words[j] = '0;
         word_written[j] = 1'b0;
      end
      for (int j = 0; j < POOL_SIZE; j++) begin
         k = (j % 4 == 0) ? PID_W'($urandom_range(1, 255)) : PID_W'($urandom);
         pid_pool[j] = (k == '0) ? PID_W'(j + 1) : k;
      end

      directed_rows = '{
         '{'{F_SEARCH, 32'h1, 8'd0, 32'h0}, GIVEN, '{ST_NOT_FOUND, 8'd0, 32'h0}},
         '{'{F_READ, 32'h1, 8'd0, 32'h0}, GIVEN, '{ST_NOT_FOUND, 8'd0, 32'h0}},
         '{'{F_DELETE, 32'h1, 8'd0, 32'h0}, GIVEN, '{ST_NOT_FOUND, 8'd0, 32'h0}},
         '{'{F_INSERT, 32'h1, 8'd0, 32'h0}, GIVEN, '{ST_OK, 8'd1, 32'h0}},
         '{'{F_INSERT, 32'h1, 8'd0, 32'h0}, GIVEN, '{ST_DUPLICATE, 8'd0, 32'h0}},
         '{'{F_INSERT, 32'h0, 8'd0, 32'h0}, GIVEN, '{ST_NOT_FOUND, 8'd0, 32'h0}},
         '{'{F_WRITE, 32'h1, 8'd15, 32'h7fffffff}, GIVEN, '{ST_OK, 8'd1, 32'h0}},
         '{'{F_WRITE, 32'h1, 8'd0, 32'h80000000}, GIVEN, '{ST_OK, 8'd1, 32'h0}},
         '{'{F_READ, 32'h1, 8'd15, 32'h0}, GIVEN, '{ST_OK, 8'd1, 32'h7fffffff}},
         '{'{F_READ, 32'h1, 8'd0, 32'hffffffff}, GIVEN, '{ST_OK, 8'd1, 32'h80000000}},
         '{'{F_WRITE, 32'h1, 8'd16, 32'h5a5a5a5a}, GIVEN, '{ST_RANGE, 8'd0, 32'h0}},
         '{'{F_READ, 32'h1, 8'd255, 32'h0}, GIVEN, '{ST_RANGE, 8'd0, 32'h0}},
         '{'{F_INSERT, 32'hffffffff, 8'd0, 32'h0}, PREDICTED, '{ST_OK, 8'd0, 32'h0}},
         '{'{F_WRITE, 32'hffffffff, 8'd15, 32'hffffffff}, PREDICTED, '{ST_OK, 8'd0, 32'h0}},
         '{'{F_READ, 32'hffffffff, 8'd15, 32'h0}, PREDICTED, '{ST_OK, 8'd0, 32'h0}},
         '{'{F_INSERT, 32'h11, 8'd0, 32'h0}, PREDICTED, '{ST_OK, 8'd0, 32'h0}},
         '{'{F_WRITE, 32'h0, 8'd0, 32'h1}, GIVEN, '{ST_NOT_FOUND, 8'd0, 32'h0}},
         '{'{F_DELETE, 32'h1, 8'd0, 32'h0}, GIVEN, '{ST_OK, 8'd1, 32'h0}},
         // key past a freed slot on its probe path must still be found
         '{'{F_SEARCH, 32'h11, 8'd0, 32'h0}, PREDICTED, '{ST_OK, 8'd0, 32'h0}},
         '{'{F_INSERT, 32'h21, 8'd0, 32'h0}, PREDICTED, '{ST_OK, 8'd0, 32'h0}},
         // reused page keeps the words of its last owner
         '{'{F_READ, 32'h21, 8'd15, 32'h0}, PREDICTED, '{ST_OK, 8'd0, 32'h0}},
         '{'{F_RESERVED_LO, 32'h11, 8'd0, 32'h0}, GIVEN, '{ST_NOT_FOUND, 8'd0, 32'h0}},
         '{'{F_RESERVED_HI, 32'h11, 8'd3, 32'h0}, GIVEN, '{ST_NOT_FOUND, 8'd0, 32'h0}},
         '{'{F_READ, 32'h0, 8'd0, 32'h0}, GIVEN, '{ST_NOT_FOUND, 8'd0, 32'h0}},
         '{'{F_DELETE, 32'h0, 8'd0, 32'h0}, GIVEN, '{ST_NOT_FOUND, 8'd0, 32'h0}}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[j])
         send_request(directed_rows[j].req, directed_rows[j].given, directed_rows[j].rsp,
                      pick_gap(1'b0));

      // fill the table, then check that full wins over duplicate
      full_rsp = '{ST_FULL, '0, '0};
      while (used_count < SLOTS) begin
         do k = $urandom; while (k == '0 || find_slot(k) != NO_SLOT);
         send_request('{F_INSERT, k, 8'd0, 32'sd0}, PREDICTED, full_rsp, pick_gap(1'b0));
      end
      do k = $urandom; while (k == '0 || find_slot(k) != NO_SLOT);
      send_request('{F_INSERT, k, 8'd0, 32'sd0}, GIVEN, full_rsp, pick_gap(1'b0));
      send_request('{F_INSERT, live_pid(), 8'd0, 32'sd0}, GIVEN, full_rsp, pick_gap(1'b0));

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(50, 200);
         quiet = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 3))
            0: insert_weight = 5;
            1: insert_weight = 15;
            2: insert_weight = 35;
            default: insert_weight = 70;
         endcase
         for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
            rq = random_request(insert_weight);
            if (rq.func <= F_DELETE)
               random_sent++;
            send_request(rq, PREDICTED, full_rsp, pick_gap(quiet));
         end
         // hold off the sender until the unit has returned everything
         if (phase == 0 || $urandom_range(0, 2) == 0)
            wait_for_drain();
         phase++;
      end

      wait_for_drain();
      repeat (SLOTS + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("double_hash_process_page_table_unit regression: pass");
      else
         $display("double_hash_process_page_table_unit regression: fail");
      $finish;
   end

endmodule

[double_hash_process_page_table_unit.f]
+incdir+src
src/dhpt_pkg.sv
src/dhpt_ctrl.sv
src/dhpt_dp.sv
src/double_hash_process_page_table_unit.sv
src/dhpt_checker.sv
verif/tb_double_hash_process_page_table_unit.sv
